[hdl/assert_macros.svh]
// assertion helpers, empty when SYNTH is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication under the synchronous reset
`define ADSR_CHK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("adsr check failed");

// next-cycle implication under the synchronous reset
`define ADSR_CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("adsr check failed");

`else

`define ADSR_CHK_NOW(lbl, ante, cons)
`define ADSR_CHK_NEXT(lbl, ante, cons)

`endif

`endif

[hdl/adsr_pkg.sv]
package adsr_pkg;

  localparam int SAMPLE_BITS     = 24;
  localparam int LEVEL_FRAC_BITS = 24;
  localparam int LEVEL_W         = LEVEL_FRAC_BITS + 1;
  localparam int CFG_W           = LEVEL_W;
  localparam int CFG_IDX_W       = 2;
  // signed working width for target, difference and new level
  localparam int WORK_W          = LEVEL_FRAC_BITS + 3;
  localparam int MUL_A_W         = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;
  localparam int MUL_B_W         = LEVEL_W;

  localparam longint ONE_VAL      = longint'(1) << LEVEL_FRAC_BITS;
  localparam longint OVERSHOT_VAL = (ONE_VAL + 500) / 1000;
  localparam longint FLOOR_VAL    = (ONE_VAL + 5000) / 10000;

  localparam logic [31:0] ATTACK_COEFF_RST  = 32'd16765584;
  localparam logic [31:0] DECAY_COEFF_RST   = 32'd16765584;
  localparam logic [31:0] RELEASE_COEFF_RST = 32'd16774889;

  typedef enum logic [2:0] {
    PH_OFF     = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK  = 2'd0,
    CFG_DECAY   = 2'd1,
    CFG_RELEASE = 2'd2,
    CFG_SUSTAIN = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    SQ_IDLE    = 3'd0,
    SQ_MUL_ENV = 3'd1,
    SQ_UPDATE  = 3'd2,
    SQ_MUL_VCA = 3'd3,
    SQ_FINISH  = 3'd4
  } seq_t;

  typedef struct packed {
    logic                          gate;
    logic signed [SAMPLE_BITS-1:0] sample_in;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [LEVEL_W-1:0]            level;
    phase_t                        phase;
  } out_word_t;

endpackage

[hdl/adsr_mul.sv]
module adsr_mul #(
  parameter int A_W = adsr_pkg::MUL_A_W,
  parameter int B_W = adsr_pkg::MUL_B_W
) (
  input  logic               clk,
  input  logic               en,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] p
);

  logic [A_W+B_W-1:0] prod_r;

  // unsigned product, registered
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

  assign p = prod_r;

endmodule

[hdl/adsr_envelope_vca_top.sv]
// channel  | handshake            | word
// ---------+----------------------+-------------------------------------
// in       | in_valid / in_ready  | in_data  : gate, sample_in
// out      | out_valid / out_ready| out_data : sample_out, level, phase
// cfg      | cfg_we               | cfg_idx, cfg_wdata (write only)
//
// each word goes through envelope multiply, level update, sample multiply
// and result load; the single shared multiplier serves both multiplies and a
// new word is taken in the load cycle
// reset (rst_n, synchronous) puts the envelope in off at level zero and
// loads the default coefficients and a sustain of one half
// a stalled out channel holds the load cycle and keeps in_ready low
`include "assert_macros.svh"

module adsr_envelope_vca_top #(
  parameter int MUL_A_W = adsr_pkg::MUL_A_W,
  parameter int MUL_B_W = adsr_pkg::MUL_B_W
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  adsr_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output adsr_pkg::out_word_t                 out_data,
  input  logic                                cfg_we,
  input  logic [adsr_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [adsr_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int SAMPLE_BITS     = adsr_pkg::SAMPLE_BITS;
  localparam int LEVEL_FRAC_BITS = adsr_pkg::LEVEL_FRAC_BITS;
  localparam int LEVEL_W         = adsr_pkg::LEVEL_W;
  localparam int WORK_W          = adsr_pkg::WORK_W;
  localparam int MUL_P_W         = MUL_A_W + MUL_B_W;

  localparam logic [LEVEL_W-1:0] ONE_LVL = LEVEL_W'(adsr_pkg::ONE_VAL);
  localparam logic signed [WORK_W-1:0] ONE_W      = WORK_W'(adsr_pkg::ONE_VAL);
  localparam logic signed [WORK_W-1:0] OVERSHOT_W = WORK_W'(adsr_pkg::OVERSHOT_VAL);
  localparam logic signed [WORK_W-1:0] FLOOR_W    = WORK_W'(adsr_pkg::FLOOR_VAL);

  // configuration registers
  logic [LEVEL_FRAC_BITS-1:0] attack_coeff_r;
  logic [LEVEL_FRAC_BITS-1:0] decay_coeff_r;
  logic [LEVEL_FRAC_BITS-1:0] release_coeff_r;
  logic [LEVEL_W-1:0]         sustain_r;

  // envelope state
  adsr_pkg::phase_t   phase_r, phase_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;

  // sequencer
  adsr_pkg::seq_t state_r, state_nxt;
  logic           out_free;
  logic           in_fire;
  logic           mul_en;
  logic           out_load;
  logic           env_upd;

  // per-word working registers
  adsr_pkg::phase_t            work_phase_r, work_phase_nxt;
  logic signed [WORK_W-1:0]    target_r, target_nxt;
  logic                        dneg_r, dneg_nxt;
  logic [MUL_A_W-1:0]          dmag_r, dmag_nxt;
  logic [LEVEL_FRAC_BITS-1:0]  coeff_r, coeff_nxt;
  logic                        xneg_r, xneg_nxt;
  logic [SAMPLE_BITS-1:0]      xmag_r, xmag_nxt;

  // result register
  logic                out_valid_r, out_valid_nxt;
  adsr_pkg::out_word_t out_data_r, out_data_nxt;

  // shared multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;

  // datapath temporaries
  logic [LEVEL_W-1:0]       sus;
  logic signed [WORK_W-1:0] sus_s;
  logic signed [WORK_W-1:0] lvl_s;
  logic signed [WORK_W-1:0] diff;
  logic [WORK_W-1:0]        diff_mag;
  logic [WORK_W-1:0]        term_u;
  logic signed [WORK_W-1:0] term_s;
  logic signed [WORK_W-1:0] nv;
  logic [SAMPLE_BITS-1:0]   vmag;

  // ---------------------------------------------------------------
  // config port: coefficients keep their low fraction bits
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_coeff_r  <= LEVEL_FRAC_BITS'(adsr_pkg::ATTACK_COEFF_RST);
      decay_coeff_r   <= LEVEL_FRAC_BITS'(adsr_pkg::DECAY_COEFF_RST);
      release_coeff_r <= LEVEL_FRAC_BITS'(adsr_pkg::RELEASE_COEFF_RST);
      sustain_r       <= LEVEL_W'(adsr_pkg::ONE_VAL >> 1);
    end else if (cfg_we) begin
      case (adsr_pkg::cfg_idx_t'(cfg_idx))
        adsr_pkg::CFG_ATTACK:  attack_coeff_r  <= cfg_wdata[LEVEL_FRAC_BITS-1:0];
        adsr_pkg::CFG_DECAY:   decay_coeff_r   <= cfg_wdata[LEVEL_FRAC_BITS-1:0];
        adsr_pkg::CFG_RELEASE: release_coeff_r <= cfg_wdata[LEVEL_FRAC_BITS-1:0];
        adsr_pkg::CFG_SUSTAIN: sustain_r       <= cfg_wdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // sustain above full scale is used as full scale
  assign sus   = (sustain_r > ONE_LVL) ? ONE_LVL : sustain_r;
  assign sus_s = $signed({2'b00, sus});
  assign lvl_s = $signed({2'b00, level_r});

  // ---------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      adsr_pkg::SQ_IDLE: begin
        if (in_valid) state_nxt = adsr_pkg::SQ_MUL_ENV;
      end
      adsr_pkg::SQ_MUL_ENV: state_nxt = adsr_pkg::SQ_UPDATE;
      adsr_pkg::SQ_UPDATE:  state_nxt = adsr_pkg::SQ_MUL_VCA;
      adsr_pkg::SQ_MUL_VCA: state_nxt = adsr_pkg::SQ_FINISH;
      adsr_pkg::SQ_FINISH: begin
        if (out_free) begin
          state_nxt = in_valid ? adsr_pkg::SQ_MUL_ENV : adsr_pkg::SQ_IDLE;
        end
      end
      default: state_nxt = adsr_pkg::SQ_IDLE;
    endcase
  end

  // ---------------------------------------------------------------
  // sequencer: outputs
  // ---------------------------------------------------------------
  always_comb begin
    in_ready = 1'b0;
    mul_en   = 1'b0;
    out_load = 1'b0;
    env_upd  = 1'b0;
    case (state_r)
      adsr_pkg::SQ_IDLE:    in_ready = 1'b1;
      adsr_pkg::SQ_MUL_ENV: mul_en   = 1'b1;
      adsr_pkg::SQ_UPDATE:  env_upd  = 1'b1;
      adsr_pkg::SQ_MUL_VCA: mul_en   = 1'b1;
      adsr_pkg::SQ_FINISH: begin
        in_ready = out_free;
        out_load = out_free;
      end
      default: ;
    endcase
  end

  assign in_fire = in_valid && in_ready;

  // ---------------------------------------------------------------
  // word intake: gate transition, stage target and |level - target|
  // ---------------------------------------------------------------
  always_comb begin
    work_phase_nxt = work_phase_r;
    target_nxt     = target_r;
    dneg_nxt       = dneg_r;
    dmag_nxt       = dmag_r;
    coeff_nxt      = coeff_r;
    xneg_nxt       = xneg_r;
    xmag_nxt       = xmag_r;
    diff           = '0;
    diff_mag       = '0;
    if (in_fire) begin
      // gate rising in release does not retrigger
      if (in_data.gate && phase_r == adsr_pkg::PH_OFF) begin
        work_phase_nxt = adsr_pkg::PH_ATTACK;
      end else if (!in_data.gate && phase_r != adsr_pkg::PH_OFF &&
                   phase_r != adsr_pkg::PH_RELEASE) begin
        work_phase_nxt = adsr_pkg::PH_RELEASE;
      end else begin
        work_phase_nxt = phase_r;
      end
      // attack, decay and release each aim past their end point
      case (work_phase_nxt)
        adsr_pkg::PH_ATTACK: begin
          target_nxt = ONE_W + OVERSHOT_W;
          coeff_nxt  = attack_coeff_r;
        end
        adsr_pkg::PH_DECAY: begin
          target_nxt = sus_s - OVERSHOT_W;
          coeff_nxt  = decay_coeff_r;
        end
        adsr_pkg::PH_RELEASE: begin
          target_nxt = -OVERSHOT_W;
          coeff_nxt  = release_coeff_r;
        end
        default: begin
          target_nxt = '0;
          coeff_nxt  = '0;
        end
      endcase
      diff     = lvl_s - target_nxt;
      dneg_nxt = diff[WORK_W-1];
      diff_mag = dneg_nxt ? WORK_W'(-diff) : WORK_W'(diff);
      dmag_nxt = MUL_A_W'(diff_mag);
      // sample magnitude; the most negative value maps to 2^(n-1)
      xneg_nxt = in_data.sample_in[SAMPLE_BITS-1];
      xmag_nxt = xneg_nxt ? (~in_data.sample_in + 1'b1) : in_data.sample_in;
    end
  end

  // ---------------------------------------------------------------
  // shared multiplier: envelope step, then sample times level
  // ---------------------------------------------------------------
  always_comb begin
    if (state_r == adsr_pkg::SQ_MUL_ENV) begin
      mul_a = dmag_r;
      mul_b = MUL_B_W'(coeff_r);
    end else begin
      mul_a = MUL_A_W'(xmag_r);
      mul_b = MUL_B_W'(level_r);
    end
  end

  adsr_mul #(
    .A_W (MUL_A_W),
    .B_W (MUL_B_W)
  ) u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // ---------------------------------------------------------------
  // envelope update: new = target + sign * (|d| * c >> F), then clamp
  // ---------------------------------------------------------------
  assign term_u = WORK_W'(prod >> LEVEL_FRAC_BITS);
  assign term_s = dneg_r ? -$signed(term_u) : $signed(term_u);
  assign nv     = target_r + term_s;

  always_comb begin
    phase_nxt = phase_r;
    level_nxt = level_r;
    if (env_upd) begin
      phase_nxt = work_phase_r;
      case (work_phase_r)
        adsr_pkg::PH_ATTACK: begin
          if (nv >= ONE_W) begin
            level_nxt = ONE_LVL;
            phase_nxt = adsr_pkg::PH_DECAY;
          end else begin
            level_nxt = LEVEL_W'(nv);
          end
        end
        adsr_pkg::PH_DECAY: begin
          // also ends at once when sustain was raised past the level
          if (nv <= sus_s) begin
            level_nxt = sus;
            phase_nxt = adsr_pkg::PH_SUSTAIN;
          end else begin
            level_nxt = LEVEL_W'(nv);
          end
        end
        adsr_pkg::PH_SUSTAIN: level_nxt = sus;
        adsr_pkg::PH_RELEASE: begin
          if (nv <= FLOOR_W) begin
            level_nxt = '0;
            phase_nxt = adsr_pkg::PH_OFF;
          end else begin
            level_nxt = LEVEL_W'(nv);
          end
        end
        default: begin
          level_nxt = '0;
          phase_nxt = adsr_pkg::PH_OFF;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------
  // result word: sample * level >> F, rounded toward zero
  // ---------------------------------------------------------------
  assign vmag = SAMPLE_BITS'(prod >> LEVEL_FRAC_BITS);

  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.sample_out = $signed(xneg_r ? (~vmag + 1'b1) : vmag);
      out_data_nxt.level      = level_r;
      out_data_nxt.phase      = phase_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // ---------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= adsr_pkg::SQ_IDLE;
      phase_r     <= adsr_pkg::PH_OFF;
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and payload registers carry no reset
  always_ff @(posedge clk) begin
    work_phase_r <= work_phase_nxt;
    target_r     <= target_nxt;
    dneg_r       <= dneg_nxt;
    dmag_r       <= dmag_nxt;
    coeff_r      <= coeff_nxt;
    xneg_r       <= xneg_nxt;
    xmag_r       <= xmag_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------
  // an accepted word always starts with the envelope multiply
  `ADSR_CHK_NEXT(a_fire_starts, in_fire, state_r == adsr_pkg::SQ_MUL_ENV)
  // off always sits at level zero
  `ADSR_CHK_NOW(a_off_zero, phase_r == adsr_pkg::PH_OFF, level_r == '0)
  // the level never passes full scale
  `ADSR_CHK_NOW(a_level_range, 1'b1, level_r <= ONE_LVL)

endmodule

[tb/adsr_tb_pkg.sv]
`timescale 1ns / 1ps

package adsr_tb_pkg;

  // q1.24 envelope constants, worked out here rather than taken from the design
  localparam longint LVL_ONE      = longint'(1) << 24;
  localparam longint LVL_OVERSHOT = (LVL_ONE + 500) / 1000;
  localparam longint LVL_FLOOR    = (LVL_ONE + 5000) / 10000;

  class adsr_scoreboard;
    logic [23:0]          attack_k;
    logic [23:0]          decay_k;
    logic [23:0]          release_k;
    logic [24:0]          sustain_k;
    adsr_pkg::phase_t     phase_now;
    longint               level_now;
    adsr_pkg::out_word_t  expected_words[$];
    int                   mismatch_count;
    int                   words_checked;

    function new();
      attack_k       = 24'd16765584;
      decay_k        = 24'd16765584;
      release_k      = 24'd16774889;
      sustain_k      = 25'(LVL_ONE / 2);
      phase_now      = adsr_pkg::PH_OFF;
      level_now      = 0;
      mismatch_count = 0;
      words_checked  = 0;
    endfunction

    function void set_register(adsr_pkg::cfg_idx_t idx, logic [adsr_pkg::CFG_W-1:0] value);
      case (idx)
        adsr_pkg::CFG_ATTACK:  attack_k  = value[23:0];
        adsr_pkg::CFG_DECAY:   decay_k   = value[23:0];
        adsr_pkg::CFG_RELEASE: release_k = value[23:0];
        adsr_pkg::CFG_SUSTAIN: sustain_k = value[24:0];
        default: ;
      endcase
    endfunction

    // d * k / 2^24 with the magnitude truncated
    function longint scale_q24(longint d, longint k);
      longint mag;
      longint prod;
      mag  = (d < 0) ? -d : d;
      prod = (mag * k) >> 24;
      return (d < 0) ? -prod : prod;
    endfunction

    function adsr_pkg::out_word_t advance_envelope(adsr_pkg::in_word_t w);
      adsr_pkg::out_word_t res;
      longint    sus;
      longint    target;
      longint    nv;
      longint    x;
      longint    prod;
      x   = $signed(w.sample_in);
      sus = (longint'(sustain_k) > LVL_ONE) ? LVL_ONE : longint'(sustain_k);

      if (w.gate && phase_now == adsr_pkg::PH_OFF) begin
        phase_now = adsr_pkg::PH_ATTACK;
      end else if (!w.gate && phase_now != adsr_pkg::PH_OFF &&
                   phase_now != adsr_pkg::PH_RELEASE) begin
        phase_now = adsr_pkg::PH_RELEASE;
      end

      case (phase_now)
        adsr_pkg::PH_ATTACK: begin
          target = LVL_ONE + LVL_OVERSHOT;
          nv = target + scale_q24(level_now - target, longint'(attack_k));
          if (nv >= LVL_ONE) begin
            nv = LVL_ONE;
            phase_now = adsr_pkg::PH_DECAY;
          end
          level_now = nv;
        end
        adsr_pkg::PH_DECAY: begin
          target = sus - LVL_OVERSHOT;
          nv = target + scale_q24(level_now - target, longint'(decay_k));
          if (nv <= sus) begin
            nv = sus;
            phase_now = adsr_pkg::PH_SUSTAIN;
          end
          level_now = nv;
        end
        adsr_pkg::PH_SUSTAIN: begin
          level_now = sus;
        end
        adsr_pkg::PH_RELEASE: begin
          nv = -LVL_OVERSHOT + scale_q24(level_now + LVL_OVERSHOT, longint'(release_k));
          if (nv <= LVL_FLOOR) begin
            nv = 0;
            phase_now = adsr_pkg::PH_OFF;
          end
          level_now = nv;
        end
        default: begin
          phase_now = adsr_pkg::PH_OFF;
          level_now = 0;
        end
      endcase

      prod           = scale_q24(x, level_now);
      res.sample_out = prod[adsr_pkg::SAMPLE_BITS-1:0];
      res.level      = level_now[adsr_pkg::LEVEL_W-1:0];
      res.phase      = phase_now;
      return res;
    endfunction

    function void note_sample(adsr_pkg::in_word_t w);
      expected_words = {expected_words, advance_envelope(w)};
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    task report_mismatch(string what);
      $display("mismatch: %s", what);
      mismatch_count++;
    endtask

    task check_word(adsr_pkg::out_word_t got);
      adsr_pkg::out_word_t want;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("word %0d arrived with nothing expected", words_checked));
        words_checked++;
        return;
      end
      want = expected_words.pop_front();
      if (got.sample_out !== want.sample_out) begin
        report_mismatch($sformatf("word %0d sample_out got %0d want %0d",
                                  words_checked, got.sample_out, want.sample_out));
      end
      if (got.level !== want.level) begin
        report_mismatch($sformatf("word %0d level got %0d want %0d",
                                  words_checked, got.level, want.level));
      end
      if (got.phase !== want.phase) begin
        report_mismatch($sformatf("word %0d phase got %0d want %0d",
                                  words_checked, got.phase, want.phase));
      end
      words_checked++;
    endtask
  endclass

endpackage

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

  // run length and pacing
  localparam int RANDOM_WORDS  = 1300;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 12;     // settle time past the last result
  localparam int HOLD_CYCLES   = 80;     // long out stall, enough to back up the input

  localparam int     SB      = adsr_pkg::SAMPLE_BITS;
  localparam longint LVL_ONE = adsr_tb_pkg::LVL_ONE;

  localparam logic signed [SB-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SB-1:0] SAMPLE_MIN = 24'sh800000;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  adsr_pkg::in_word_t             in_data   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  adsr_pkg::out_word_t            out_data;
  logic                           cfg_we    = 1'b0;
  logic [adsr_pkg::CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [adsr_pkg::CFG_W-1:0]     cfg_wdata = '0;

  adsr_tb_pkg::adsr_scoreboard sb = new();

  // shared pacing knobs: steady_flow turns off the random gaps on both sides
  bit  steady_flow = 1'b0;
  int  words_taken = 0;
  int  cycle_count = 0;

  // current register values, so a phase can change only the sustain level
  logic [23:0] cur_att = 24'd16765584;
  logic [23:0] cur_dec = 24'd16765584;
  logic [23:0] cur_rel = 24'd16774889;
  logic [24:0] cur_sus = 25'(LVL_ONE / 2);

  adsr_envelope_vca_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // watchdog: a hung handshake ends the run here
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  // random audio sample, with the extremes and the values around zero now and then
  function automatic logic signed [SB-1:0] rand_sample();
    case ($urandom_range(0, 15))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return '0;
      3:       return '1;
      default: return 24'($urandom());
    endcase
  endfunction

  // pole per sample: mostly fast enough that stages finish within a note
  function automatic logic [23:0] rand_coeff();
    case ($urandom_range(0, 11))
      0:       return '0;     // instant stage
      1:       return '1;     // slowest pole, stage effectively never ends
      2:       return 24'(LVL_ONE - $urandom_range(1 << 10, 1 << 14));
      default: return 24'(LVL_ONE - $urandom_range(1 << 19, (1 << 24) - 1));
    endcase
  endfunction

  function automatic logic [24:0] rand_sustain();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 25'(LVL_ONE);
      2:       return '1;     // above full scale, used as full scale
      3:       return 25'($urandom_range(32'(LVL_ONE + 1), (1 << 25) - 1));
      default: return 25'($urandom_range(1, (1 << 24) - 1));
    endcase
  endfunction

  // write all four registers, one per cycle; only called with nothing in flight
  task automatic apply_cfg(input logic [23:0] att, input logic [23:0] dec,
                           input logic [23:0] rel, input logic [24:0] sus);
    adsr_pkg::cfg_idx_t         idx_list[4];
    logic [adsr_pkg::CFG_W-1:0] val_list[4];
    idx_list = '{adsr_pkg::CFG_ATTACK, adsr_pkg::CFG_DECAY,
                 adsr_pkg::CFG_RELEASE, adsr_pkg::CFG_SUSTAIN};
    val_list = '{adsr_pkg::CFG_W'(att), adsr_pkg::CFG_W'(dec),
                 adsr_pkg::CFG_W'(rel), adsr_pkg::CFG_W'(sus)};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idx_list[i];
      cfg_wdata <= val_list[i];
      sb.set_register(idx_list[i], val_list[i]);
      @(posedge clk);
    end
    cfg_we  <= 1'b0;
    cur_att = att;
    cur_dec = dec;
    cur_rel = rel;
    cur_sus = sus;
  endtask

  // offer one word and hold it until taken; valid stays up across back-to-back words
  task automatic send_word(input logic gate_bit, input logic signed [SB-1:0] sample);
    int                 gap;
    adsr_pkg::in_word_t w;
    gap         = steady_flow ? 0 : $urandom_range(0, 3);
    w.gate      = gate_bit;
    w.sample_in = sample;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // taken at this edge: the envelope steps now, in input order
    sb.note_sample(w);
  endtask

  // stop offering and wait for every expected word, then let the sequencer settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: random stalls, two long hold-offs, every taken word checked
  initial begin : result_side
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 3);
      // long stall while the input side keeps offering, so in_ready has to drop
      if (words_taken == 300 || words_taken == 900) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_word(out_data);
      words_taken++;
    end
  end

  initial begin : stimulus
    int   random_sent;
    int   chunk;
    int   note_left;
    logic note_gate;
    logic gate_bit;
    random_sent = 0;
    note_left   = 0;
    note_gate   = 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset coefficients: a slow attack gets under way from zero
    send_word(1'b1, SAMPLE_MAX);
    send_word(1'b1, SAMPLE_MIN);

    // all poles zero: every stage jumps to its end point in one sample
    drain_results();
    apply_cfg('0, '0, '0, 25'(LVL_ONE / 2));
    send_word(1'b1, rand_sample());     // attack straight to full scale
    send_word(1'b1, -24'sd1);           // decay straight to sustain
    send_word(1'b1, rand_sample());     // sustain holds
    send_word(1'b0, '0);                // release straight to off
    send_word(1'b0, rand_sample());     // off holds zero

    // sustain above full scale is clamped to full scale
    drain_results();
    apply_cfg('0, '0, '0, '1);
    send_word(1'b1, SAMPLE_MAX);
    send_word(1'b1, SAMPLE_MIN);
    send_word(1'b1, rand_sample());

    // sustain dropped to zero while sustaining: the level follows
    drain_results();
    apply_cfg('0, '0, '0, '0);
    send_word(1'b1, SAMPLE_MAX);

    // gate back high during release must not retrigger until off
    drain_results();
    apply_cfg('0, '1, 24'h200000, 25'(LVL_ONE / 2));
    send_word(1'b1, rand_sample());     // level follows the raised sustain
    send_word(1'b0, rand_sample());     // release, pole 1/8
    repeat (5) send_word(1'b1, rand_sample());  // release runs out, then attack, slow decay

    // sustain raised above the decaying level: decay ends at once
    drain_results();
    apply_cfg('1, '1, '1, 25'(LVL_ONE));
    send_word(1'b1, rand_sample());

    // random notes: gate held for a while then dropped, envelope state kept across
    // register changes so new settings land in the middle of stages
    while (random_sent < RANDOM_WORDS) begin
      drain_results();
      if ($urandom_range(0, 2) == 0) begin
        apply_cfg(cur_att, cur_dec, cur_rel, rand_sustain());
      end else begin
        apply_cfg(rand_coeff(), rand_coeff(), rand_coeff(), rand_sustain());
      end
      steady_flow = ($urandom_range(0, 3) == 0);
      chunk = $urandom_range(40, 120);
      repeat (chunk) begin
        if (note_left == 0) begin
          note_gate = ~note_gate;
          note_left = note_gate ? $urandom_range(3, 90) : $urandom_range(3, 70);
        end
        gate_bit = note_gate;
        // occasional stray gate value breaks up the note
        if ($urandom_range(0, 9) == 0) gate_bit = 1'($urandom());
        send_word(gate_bit, rand_sample());
        note_left--;
        random_sent++;
      end
    end

    drain_results();
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
